// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define CCT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cct: same-cycle check failed");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define CCT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cct: next-cycle check failed");

`endif

// ----- sv/cct_pkg.sv -----
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and codes of the character class transliterator.
// ----------------------------------------------------------------------------
package cct_pkg;

  // default capacity of each expanded class
  localparam int unsigned CLASS_DEPTH = 256;
  // one map entry per byte value
  localparam int unsigned MAP_DEPTH   = 256;
  localparam int unsigned BYTE_W      = 8;

  // range marker inside a description
  localparam logic [7:0] DASH = 8'h2D;

  // item kinds
  localparam logic [2:0] KIND_SRC   = 3'd0;
  localparam logic [2:0] KIND_DST   = 3'd1;
  localparam logic [2:0] KIND_FIN   = 3'd2;
  localparam logic [2:0] KIND_DATA  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // finish status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_REVERSED = 3'd1;
  localparam logic [2:0] STATUS_EMPTY    = 3'd2;
  localparam logic [2:0] STATUS_MISMATCH = 3'd3;
  localparam logic [2:0] STATUS_OVERFLOW = 3'd4;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_FLUSH,
    S_CHECK,
    S_BUILD,
    S_LOOKUP,
    S_EMIT
  } state_e;

endpackage

// ----- sv/char_class_transliterator.sv -----
// Data byte: accepted in idle, looked up in S_LOOKUP, handed out in S_EMIT; no new
// item is taken before that. Description byte: S_PUT writes each byte put into a
// class (a range x-y writes x to y via the single class write port, dropped bytes
// included). Finish: S_FLUSH writes pending lookahead bytes, S_CHECK sets status,
// S_BUILD fills the map on success, and S_EMIT outputs the result.
// Reset (async, active low) empties classes, clears flags and the map valid bits.
// ----------------------------------------------------------------------------
// char_class_transliterator
// tr-style byte translator: expands source and destination classes, checks
// them at finish, builds a byte map and translates data bytes through it.
// ----------------------------------------------------------------------------
module char_class_transliterator #(
  parameter int unsigned CLASS_DEPTH = cct_pkg::CLASS_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o
);

  localparam int unsigned AW = $clog2(CLASS_DEPTH);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned MW = $clog2(cct_pkg::MAP_DEPTH);

  // sequencer
  cct_pkg::state_e state_q, state_d;

  // per-class length and two-byte lookahead (index 0 source, 1 destination)
  logic [LW-1:0] len_q   [2];
  logic [LW-1:0] len_d   [2];
  logic [7:0]    la0_q   [2];
  logic [7:0]    la0_d   [2];
  logic [7:0]    la1_q   [2];
  logic [7:0]    la1_d   [2];
  logic [1:0]    lacnt_q [2];
  logic [1:0]    lacnt_d [2];

  // sticky flags and last status
  logic       rev_q, rev_d;
  logic       ovf_q, ovf_d;
  logic [2:0] err_q, err_d;

  // map valid bits: an entry that is not taken reads as its own index
  logic [cct_pkg::MAP_DEPTH-1:0] taken_q, taken_d;

  // byte run being written
  logic       run_chan_q, run_chan_d;
  logic [7:0] run_cur_q, run_cur_d;
  logic [7:0] run_end_q, run_end_d;

  // map build walk
  logic [LW-1:0] bi_q, bi_d;
  logic          pv_q, pv_d;

  // data lookup
  logic [7:0] data_ch_q, data_ch_d;
  logic       data_tk_q, data_tk_d;

  // pending result and output register
  logic [7:0] res_byte_q, res_byte_d;
  logic [2:0] res_status_q, res_status_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic [2:0] out_status_q, out_status_d;

  // shared class write unit
  logic       put_en;
  logic       put_chan;
  logic [7:0] put_byte;
  logic       put_ok;

  // memory ports
  logic          src_we, dst_we;
  logic [AW-1:0] cls_raddr;
  logic [7:0]    src_rdata, dst_rdata;
  logic          map_we;
  logic [MW-1:0] map_waddr;
  logic [7:0]    map_wdata;
  logic [MW-1:0] map_raddr;
  logic [7:0]    map_rdata;

  logic          in_xfer;
  logic          chan_sel;
  logic [2:0]    check_st;

  assign in_ready_o = (state_q == cct_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // kind bit 0 selects source or destination for description bytes
  assign chan_sel   = kind_i[0];

  // class capacity check of the write unit
  assign put_ok = (len_q[put_chan] < LW'(CLASS_DEPTH));

  // class memory writes go to the selected class at its current length
  assign src_we    = put_en && put_ok && !put_chan;
  assign dst_we    = put_en && put_ok && put_chan;
  assign cls_raddr = bi_q[AW-1:0];
  assign map_raddr = ch_i;

  // finish checks in priority order
  always_comb begin
    if (rev_q) begin
      check_st = cct_pkg::STATUS_REVERSED;
    end else if (len_q[0] == '0) begin
      check_st = cct_pkg::STATUS_EMPTY;
    end else if (len_q[0] != len_q[1]) begin
      check_st = cct_pkg::STATUS_MISMATCH;
    end else if (ovf_q) begin
      check_st = cct_pkg::STATUS_OVERFLOW;
    end else begin
      check_st = cct_pkg::STATUS_OK;
    end
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    la0_d        = la0_q;
    la1_d        = la1_q;
    lacnt_d      = lacnt_q;
    rev_d        = rev_q;
    ovf_d        = ovf_q;
    err_d        = err_q;
    taken_d      = taken_q;
    run_chan_d   = run_chan_q;
    run_cur_d    = run_cur_q;
    run_end_d    = run_end_q;
    bi_d         = bi_q;
    pv_d         = pv_q;
    data_ch_d    = data_ch_q;
    data_tk_d    = data_tk_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    put_en       = 1'b0;
    put_chan     = run_chan_q;
    put_byte     = run_cur_q;
    map_we       = 1'b0;
    map_waddr    = src_rdata;
    map_wdata    = dst_rdata;

    // output register drains on a transfer
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      cct_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (kind_i)
            cct_pkg::KIND_SRC, cct_pkg::KIND_DST: begin
              if (lacnt_q[chan_sel] == 2'd0) begin
                la0_d[chan_sel]   = ch_i;
                lacnt_d[chan_sel] = 2'd1;
              end else if (lacnt_q[chan_sel] == 2'd1) begin
                la1_d[chan_sel]   = ch_i;
                lacnt_d[chan_sel] = 2'd2;
              end else if (la1_q[chan_sel] == cct_pkg::DASH) begin
                // complete x-y triple
                lacnt_d[chan_sel] = 2'd0;
                if (la0_q[chan_sel] > ch_i) begin
                  rev_d = 1'b1;
                end else begin
                  run_chan_d = chan_sel;
                  run_cur_d  = la0_q[chan_sel];
                  run_end_d  = ch_i;
                  state_d    = cct_pkg::S_PUT;
                end
              end else begin
                // oldest byte is a literal, shift the window
                run_chan_d      = chan_sel;
                run_cur_d       = la0_q[chan_sel];
                run_end_d       = la0_q[chan_sel];
                la0_d[chan_sel] = la1_q[chan_sel];
                la1_d[chan_sel] = ch_i;
                state_d         = cct_pkg::S_PUT;
              end
            end
            cct_pkg::KIND_FIN: begin
              state_d = cct_pkg::S_FLUSH;
            end
            cct_pkg::KIND_DATA: begin
              data_ch_d = ch_i;
              data_tk_d = taken_q[ch_i];
              state_d   = cct_pkg::S_LOOKUP;
            end
            cct_pkg::KIND_CLEAR: begin
              len_d   = '{default: '0};
              lacnt_d = '{default: '0};
              rev_d   = 1'b0;
              ovf_d   = 1'b0;
              err_d   = cct_pkg::STATUS_OK;
              taken_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // write one byte of the run per cycle
      cct_pkg::S_PUT: begin
        put_en = 1'b1;
        if (run_cur_q == run_end_q) begin
          state_d = cct_pkg::S_IDLE;
        end else begin
          run_cur_d = run_cur_q + 8'd1;
        end
      end

      // pending lookahead bytes become literals, source first
      cct_pkg::S_FLUSH: begin
        if (lacnt_q[0] != 2'd0) begin
          put_en     = 1'b1;
          put_chan   = 1'b0;
          put_byte   = la0_q[0];
          la0_d[0]   = la1_q[0];
          lacnt_d[0] = lacnt_q[0] - 2'd1;
        end else if (lacnt_q[1] != 2'd0) begin
          put_en     = 1'b1;
          put_chan   = 1'b1;
          put_byte   = la0_q[1];
          la0_d[1]   = la1_q[1];
          lacnt_d[1] = lacnt_q[1] - 2'd1;
        end else begin
          state_d = cct_pkg::S_CHECK;
        end
      end

      // report status, reset the map to identity, build on success
      cct_pkg::S_CHECK: begin
        taken_d      = '0;
        err_d        = check_st;
        res_byte_d   = '0;
        res_status_d = check_st;
        bi_d         = '0;
        pv_d         = 1'b0;
        if (check_st == cct_pkg::STATUS_OK) begin
          state_d = cct_pkg::S_BUILD;
        end else begin
          state_d = cct_pkg::S_EMIT;
        end
      end

      // read one class entry pair per cycle, first occurrence wins
      cct_pkg::S_BUILD: begin
        if (bi_q != len_q[0]) begin
          pv_d = 1'b1;
          bi_d = bi_q + LW'(1);
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q && !taken_q[src_rdata]) begin
          map_we             = 1'b1;
          taken_d[src_rdata] = 1'b1;
        end
        if ((bi_q == len_q[0]) && !pv_q) begin
          state_d = cct_pkg::S_EMIT;
        end
      end

      // map read data is ready, pass the byte if its entry is not taken
      cct_pkg::S_LOOKUP: begin
        res_byte_d   = data_tk_q ? map_rdata : data_ch_q;
        res_status_d = err_q;
        state_d      = cct_pkg::S_EMIT;
      end

      // hand the result to the output register once it is free
      cct_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_byte_d   = res_byte_q;
          out_status_d = res_status_q;
          state_d      = cct_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = cct_pkg::S_IDLE;
      end
    endcase

    // shared write unit: append or record overflow
    if (put_en) begin
      if (put_ok) begin
        len_d[put_chan] = len_q[put_chan] + LW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cct_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '{default: '0};
      lacnt_q     <= '{default: '0};
      rev_q       <= 1'b0;
      ovf_q       <= 1'b0;
      err_q       <= cct_pkg::STATUS_OK;
      taken_q     <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      lacnt_q     <= lacnt_d;
      rev_q       <= rev_d;
      ovf_q       <= ovf_d;
      err_q       <= err_d;
      taken_q     <= taken_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    la0_q        <= la0_d;
    la1_q        <= la1_d;
    run_chan_q   <= run_chan_d;
    run_cur_q    <= run_cur_d;
    run_end_q    <= run_end_d;
    bi_q         <= bi_d;
    data_ch_q    <= data_ch_d;
    data_tk_q    <= data_tk_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
  end

  // source class storage
  cct_ram #(
    .WIDTH(cct_pkg::BYTE_W),
    .DEPTH(CLASS_DEPTH)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(len_q[0][AW-1:0]),
    .wdata_i(put_byte),
    .raddr_i(cls_raddr),
    .rdata_o(src_rdata)
  );

  // destination class storage
  cct_ram #(
    .WIDTH(cct_pkg::BYTE_W),
    .DEPTH(CLASS_DEPTH)
  ) u_dst_ram (
    .clk_i  (clk_i),
    .we_i   (dst_we),
    .waddr_i(len_q[1][AW-1:0]),
    .wdata_i(put_byte),
    .raddr_i(cls_raddr),
    .rdata_o(dst_rdata)
  );

  // byte map storage
  cct_ram #(
    .WIDTH(cct_pkg::BYTE_W),
    .DEPTH(cct_pkg::MAP_DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = out_status_q;

endmodule

// ----- sv/cct_ram.sv -----
// ----------------------------------------------------------------------------
// cct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cct_ram #(
  parameter int unsigned WIDTH = cct_pkg::BYTE_W,
  parameter int unsigned DEPTH = cct_pkg::CLASS_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/cct_checker.sv -----
// ----------------------------------------------------------------------------
// cct_checker
// Port-level assertions for the character class transliterator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] kind_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] status_o
);

  // a stalled result holds its payload
  `CCT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(status_o))

  // results only carry a defined status code
  `CCT_ASSERT_IMPL(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= cct_pkg::STATUS_OVERFLOW)

  // a data transfer starts the map lookup, no new item meanwhile
  `CCT_ASSERT_NEXT(a_data_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (kind_i == cct_pkg::KIND_DATA), !in_ready_o)

  // a finish transfer starts the flush and check sequence
  `CCT_ASSERT_NEXT(a_fin_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (kind_i == cct_pkg::KIND_FIN), !in_ready_o)

endmodule

bind char_class_transliterator cct_checker u_cct_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .kind_i     (kind_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_byte_o (out_byte_o),
  .status_o   (status_o)
);
